// ===== hw/rtl/kbdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// kbdsc_pkg
// Shared types and constants of the set-1 scancode event decoder.
// ----------------------------------------------------------------------------
package kbdsc_pkg;

  localparam int unsigned DefQueueDepth = 64;

  localparam int unsigned KindW  = 4;
  localparam int unsigned CharW  = 8;
  localparam int unsigned EventW = KindW + CharW;

  typedef enum logic [1:0] {
    REQ_SCAN = 2'd0,
    REQ_POP  = 2'd1,
    REQ_MAP  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR  = 4'd0,
    KIND_BKSP  = 4'd1,
    KIND_ENTER = 4'd2,
    KIND_UP    = 4'd3,
    KIND_DOWN  = 4'd4,
    KIND_LEFT  = 4'd5,
    KIND_RIGHT = 4'd6,
    KIND_PGUP  = 4'd7,
    KIND_PGDN  = 4'd8
  } kind_e;

  // Set-1 scancodes.
  localparam logic [7:0] ScExtPrefix = 8'hE0;
  localparam logic [7:0] ScUp        = 8'h48;
  localparam logic [7:0] ScDown      = 8'h50;
  localparam logic [7:0] ScLeft      = 8'h4B;
  localparam logic [7:0] ScRight     = 8'h4D;
  localparam logic [7:0] ScPgUp      = 8'h49;
  localparam logic [7:0] ScPgDn      = 8'h51;
  localparam logic [7:0] ScBksp      = 8'h0E;
  localparam logic [7:0] ScEnter     = 8'h1C;
  localparam logic [7:0] ScCtrlMake  = 8'h1D;
  localparam logic [7:0] ScCtrlBreak = 8'h9D;
  localparam logic [7:0] ScLShMake   = 8'h2A;
  localparam logic [7:0] ScRShMake   = 8'h36;
  localparam logic [7:0] ScLShBreak  = 8'hAA;
  localparam logic [7:0] ScRShBreak  = 8'hB6;

  // Decoded transaction as seen by the queue stage.
  typedef struct packed {
    logic             pop;
    logic             push;
    kind_e            kind;
    logic [CharW-1:0] ch;
  } op_t;

endpackage

// ===== hw/rtl/keyboard_scancode_event_decoder.sv =====
// ----------------------------------------------------------------------------
// keyboard_scancode_event_decoder
// Set-1 keyboard scancode decoder with an event queue held in a memory.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  in      | input     | in_valid_i / in_stall_o | req_type, scan_byte, map_*
//  out     | output    | out_valid_o/out_stall_i | ev_valid, ev_kind, ev_char,
//          |           |                         | queue_level, dropped
//
//  One transaction per cycle while the input is not stalled: the accept
//  cycle reads the keymap and the queue memory, and when the decode stage
//  fires it updates the queue and loads the output register.
//  Reset clears the pointers, the fill count and the prefix, shift and ctrl
//  state; the keymap and the queue memory are not cleared.
//  A stall on the output holds the decode stage; the input stalls only when
//  the decode stage is full and the full output register is stalled.
// ----------------------------------------------------------------------------
module keyboard_scancode_event_decoder
  import kbdsc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH),
  localparam int unsigned LvlW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       scan_byte_i,
  input  logic             map_select_i,
  input  logic [6:0]       map_index_i,
  input  logic [CharW-1:0] map_char_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             ev_valid_o,
  output logic [KindW-1:0] ev_kind_o,
  output logic [CharW-1:0] ev_char_o,
  output logic [LvlW-1:0]  queue_level_o,
  output logic             dropped_o
);

  logic accept;
  logic advance;
  logic fire;
  op_t  op;

  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;

  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d, rd_ptr_inc;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_inc;
  logic [LvlW-1:0] count_q, count_d;
  logic [PtrW-1:0] rd_addr;

  logic [EventW-1:0] queue_mem [QUEUE_DEPTH];
  logic [EventW-1:0] rd_data_q;
  logic [EventW-1:0] byp_data_q;
  logic              byp_hit_q;
  logic [EventW-1:0] wr_data;
  logic [EventW-1:0] pop_data;

  logic full;
  logic pop_ok;
  logic push_ok;

  logic             ev_valid_q;
  logic [KindW-1:0] ev_kind_q;
  logic [CharW-1:0] ev_char_q;
  logic [LvlW-1:0]  level_q;
  logic             dropped_q;

  kbdsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .scan_byte_i  (scan_byte_i),
    .map_select_i (map_select_i),
    .map_index_i  (map_index_i),
    .map_char_i   (map_char_i),
    .op_o         (op)
  );

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign fire       = s2_valid_q & advance;
  assign in_stall_o = s2_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  assign full    = (count_q == LvlW'(QUEUE_DEPTH));
  assign pop_ok  = op.pop & (count_q != '0);
  assign push_ok = op.push & ~full;
  assign wr_data = {op.kind, op.ch};

  assign rd_ptr_inc = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_inc = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;

  // A pop leaving the decode stage in this cycle moves the head forward.
  assign rd_addr = (fire & pop_ok) ? rd_ptr_inc : rd_ptr_q;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (fire) begin
      if (pop_ok) begin
        rd_ptr_d = rd_ptr_inc;
        count_d  = count_q - 1'b1;
      end
      if (push_ok) begin
        wr_ptr_d = wr_ptr_inc;
        count_d  = count_q + 1'b1;
      end
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (accept) begin
      s2_valid_d = 1'b1;
    end else if (fire) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && push_ok) begin
      queue_mem[wr_ptr_q] <= wr_data;
    end
  end

  // The memory returns old data when the head entry is written in the same
  // cycle, so that write is captured on the side.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q  <= queue_mem[rd_addr];
      byp_data_q <= wr_data;
      byp_hit_q  <= fire & push_ok & (wr_ptr_q == rd_addr);
    end
  end

  assign pop_data = byp_hit_q ? byp_data_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ev_valid_q <= pop_ok;
      ev_kind_q  <= pop_ok ? pop_data[EventW-1:CharW] : '0;
      ev_char_q  <= pop_ok ? pop_data[CharW-1:0] : '0;
      level_q    <= count_d;
      dropped_q  <= op.push & full;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ev_valid_o    = ev_valid_q;
  assign ev_kind_o     = ev_kind_q;
  assign ev_char_o     = ev_char_q;
  assign queue_level_o = level_q;
  assign dropped_o     = dropped_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LvlW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == LvlW'(QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree with empty or full queue");

  a_pop_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ev_valid_o && dropped_o))
    else $error("result both popped and dropped");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !advance) |=> s2_valid_q)
    else $error("decode stage lost a transaction under stall");

endmodule

// ===== hw/rtl/kbdsc_front.sv =====
// ----------------------------------------------------------------------------
// kbdsc_front
// Scancode decoder front end: prefix, shift and ctrl tracking, the keymap
// memory and the ctrl fold of looked-up characters.
// ----------------------------------------------------------------------------
module kbdsc_front
  import kbdsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       scan_byte_i,
  input  logic             map_select_i,
  input  logic [6:0]       map_index_i,
  input  logic [CharW-1:0] map_char_i,
  output op_t              op_o
);

  logic [CharW-1:0] keymap [256];
  logic [CharW-1:0] key_rd_q;

  logic prefix_q, prefix_d;
  logic shift_q, shift_d;
  logic ctrl_q, ctrl_d;

  // Registered descriptor of the accepted transaction.
  logic  pop_q, pop_d;
  logic  fixed_q, fixed_d;
  logic  lookup_q, lookup_d;
  logic  fold_q;
  kind_e kind_q, kind_d;

  req_e       req;
  logic [7:0] map_addr;
  logic [7:0] look_addr;
  logic [CharW-1:0] folded;

  assign req       = req_e'(req_type_i);
  assign map_addr  = {map_select_i, map_index_i};
  assign look_addr = {shift_q, scan_byte_i[6:0]};

  always_comb begin
    prefix_d = prefix_q;
    shift_d  = shift_q;
    ctrl_d   = ctrl_q;
    pop_d    = 1'b0;
    fixed_d  = 1'b0;
    lookup_d = 1'b0;
    kind_d   = KIND_CHAR;
    case (req)
      REQ_POP: begin
        pop_d = 1'b1;
      end
      REQ_SCAN: begin
        if (scan_byte_i == ScExtPrefix) begin
          prefix_d = 1'b1;
        end else if (prefix_q) begin
          prefix_d = 1'b0;
          fixed_d  = 1'b1;
          case (scan_byte_i)
            ScCtrlMake:  begin ctrl_d = 1'b1; fixed_d = 1'b0; end
            ScCtrlBreak: begin ctrl_d = 1'b0; fixed_d = 1'b0; end
            ScUp:        kind_d = KIND_UP;
            ScDown:      kind_d = KIND_DOWN;
            ScLeft:      kind_d = KIND_LEFT;
            ScRight:     kind_d = KIND_RIGHT;
            ScPgUp:      kind_d = KIND_PGUP;
            ScPgDn:      kind_d = KIND_PGDN;
            default:     fixed_d = 1'b0;
          endcase
        end else begin
          fixed_d = 1'b1;
          case (scan_byte_i)
            ScLShMake, ScRShMake:   begin shift_d = 1'b1; fixed_d = 1'b0; end
            ScLShBreak, ScRShBreak: begin shift_d = 1'b0; fixed_d = 1'b0; end
            ScCtrlMake:  begin ctrl_d = 1'b1; fixed_d = 1'b0; end
            ScCtrlBreak: begin ctrl_d = 1'b0; fixed_d = 1'b0; end
            ScBksp:      kind_d = KIND_BKSP;
            ScEnter:     kind_d = KIND_ENTER;
            ScUp:        kind_d = KIND_UP;
            ScDown:      kind_d = KIND_DOWN;
            ScPgUp:      kind_d = KIND_PGUP;
            ScPgDn:      kind_d = KIND_PGDN;
            default: begin
              // Other make codes go through the keymap; break codes are ignored.
              fixed_d  = 1'b0;
              lookup_d = ~scan_byte_i[7];
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
    end else if (accept_i) begin
      prefix_q <= prefix_d;
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pop_q    <= pop_d;
      fixed_q  <= fixed_d;
      lookup_q <= lookup_d;
      kind_q   <= kind_d;
      fold_q   <= ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && req == REQ_MAP) begin
      keymap[map_addr] <= map_char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      key_rd_q <= keymap[look_addr];
    end
  end

  // With ctrl held, letters become control codes 1 to 26.
  always_comb begin
    folded = key_rd_q;
    if (fold_q) begin
      if (key_rd_q inside {[8'h41:8'h5A]}) begin
        folded = key_rd_q - 8'h40;
      end else if (key_rd_q inside {[8'h61:8'h7A]}) begin
        folded = key_rd_q - 8'h60;
      end
    end
  end

  always_comb begin
    op_o.pop  = pop_q;
    op_o.push = fixed_q | (lookup_q & (folded != '0));
    op_o.kind = fixed_q ? kind_q : KIND_CHAR;
    op_o.ch   = fixed_q ? '0 : folded;
  end

endmodule

// ===== bench/tb_keyboard_scancode_event_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_keyboard_scancode_event_decoder
// Self-checking bench for the set-1 scancode event decoder. A scoreboard
// class predicts every reply from its own copy of the prefix, shift and ctrl
// state, the keymaps and the event queue. Each reply is compared field by
// field with the oldest prediction. Stimulus is a directed sequence followed
// by random scancode streams with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_keyboard_scancode_event_decoder;
  import kbdsc_pkg::*;

  localparam int unsigned Depth      = DefQueueDepth;
  localparam int unsigned LvlW       = $clog2(Depth + 1);
  localparam int          CycleLimit = 400_000;
  localparam int          RandSteps  = 340;

  localparam logic [7:0] CharUpA = 8'h41;
  localparam logic [7:0] CharUpZ = 8'h5A;
  localparam logic [7:0] CharLoA = 8'h61;
  localparam logic [7:0] CharLoZ = 8'h7A;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } key_ev_t;

  typedef struct packed {
    logic            ev_valid;
    kind_e           kind;
    logic [7:0]      ch;
    logic [LvlW-1:0] level;
    logic            dropped;
  } reply_t;

  class kbd_event_board;
    reply_t     expected_replies[$];
    key_ev_t    key_events[$];
    logic [7:0] keymap[256];
    bit         mapped[256];
    bit         pfx;
    bit         shift_on;
    bit         ctrl_on;
    int         errors;

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Returns 1 when the queue was full and the event was lost.
    function bit push_event(kind_e k, logic [7:0] c);
      key_ev_t e;
      if (key_events.size() >= Depth) return 1'b1;
      e.kind = k;
      e.ch   = c;
      key_events.push_back(e);
      return 1'b0;
    endfunction

    function bit decode_scan(logic [7:0] sc);
      logic [7:0] c;
      if (sc == ScExtPrefix) begin
        pfx = 1'b1;
        return 1'b0;
      end
      if (pfx) begin
        pfx = 1'b0;
        case (sc)
          ScCtrlMake:  ctrl_on = 1'b1;
          ScCtrlBreak: ctrl_on = 1'b0;
          ScUp:        return push_event(KIND_UP, 8'h00);
          ScDown:      return push_event(KIND_DOWN, 8'h00);
          ScLeft:      return push_event(KIND_LEFT, 8'h00);
          ScRight:     return push_event(KIND_RIGHT, 8'h00);
          ScPgUp:      return push_event(KIND_PGUP, 8'h00);
          ScPgDn:      return push_event(KIND_PGDN, 8'h00);
          default: ;
        endcase
        return 1'b0;
      end
      case (sc)
        ScLShMake, ScRShMake:   shift_on = 1'b1;
        ScLShBreak, ScRShBreak: shift_on = 1'b0;
        ScCtrlMake:             ctrl_on = 1'b1;
        ScCtrlBreak:            ctrl_on = 1'b0;
        ScBksp:                 return push_event(KIND_BKSP, 8'h00);
        ScEnter:                return push_event(KIND_ENTER, 8'h00);
        ScUp:                   return push_event(KIND_UP, 8'h00);
        ScDown:                 return push_event(KIND_DOWN, 8'h00);
        ScPgUp:                 return push_event(KIND_PGUP, 8'h00);
        ScPgDn:                 return push_event(KIND_PGDN, 8'h00);
        default: begin
          if (sc[7]) return 1'b0;
          c = keymap[{shift_on, sc[6:0]}];
          if (ctrl_on && c >= CharUpA && c <= CharUpZ) c = c - CharUpA + 8'd1;
          else if (ctrl_on && c >= CharLoA && c <= CharLoZ) c = c - CharLoA + 8'd1;
          if (c != 8'h00) return push_event(KIND_CHAR, c);
        end
      endcase
      return 1'b0;
    endfunction

    // Keymap index that this scancode would look up if it is still unloaded,
    // or -1 when no unloaded entry would be read.
    function int unloaded_entry(logic [7:0] sc);
      int idx;
      if (pfx || sc[7]) return -1;
      case (sc)
        ScLShMake, ScRShMake, ScCtrlMake, ScBksp, ScEnter,
        ScUp, ScDown, ScPgUp, ScPgDn: return -1;
        default: ;
      endcase
      idx = {shift_on, sc[6:0]};
      return mapped[idx] ? -1 : idx;
    endfunction

    function void note_request(req_e r, logic [7:0] sc, logic sel, logic [6:0] idx,
                               logic [7:0] chr);
      reply_t  rep;
      key_ev_t e;
      rep = '0;
      case (r)
        REQ_SCAN: rep.dropped = decode_scan(sc);
        REQ_POP: begin
          if (key_events.size() != 0) begin
            e = key_events.pop_front();
            rep.ev_valid = 1'b1;
            rep.kind     = e.kind;
            rep.ch       = e.ch;
          end
        end
        REQ_MAP: begin
          keymap[{sel, idx}] = chr;
          mapped[{sel, idx}] = 1'b1;
        end
        default: ;
      endcase
      rep.level = LvlW'(key_events.size());
      expected_replies.push_back(rep);
    endfunction

    task check_reply(logic v, logic [3:0] k, logic [7:0] c, logic [LvlW-1:0] lvl,
                     logic d);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report("reply with no request outstanding");
        return;
      end
      want = expected_replies.pop_front();
      if (v !== want.ev_valid)
        report($sformatf("ev_valid %0b, expected %0b", v, want.ev_valid));
      if (k !== want.kind)
        report($sformatf("ev_kind %0d, expected %0d", k, want.kind));
      if (c !== want.ch)
        report($sformatf("ev_char %02h, expected %02h", c, want.ch));
      if (lvl !== want.level)
        report($sformatf("queue_level %0d, expected %0d", lvl, want.level));
      if (d !== want.dropped)
        report($sformatf("dropped %0b, expected %0b", d, want.dropped));
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      req_type_i = REQ_NONE;
  logic [7:0]      scan_byte_i = 8'h00;
  logic            map_select_i = 1'b0;
  logic [6:0]      map_index_i = 7'h00;
  logic [7:0]      map_char_i = 8'h00;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            ev_valid_o;
  logic [3:0]      ev_kind_o;
  logic [7:0]      ev_char_o;
  logic [LvlW-1:0] queue_level_o;
  logic            dropped_o;

  kbd_event_board board;
  int             burst_left = 0;
  int             cycle_count = 0;
  rx_mode_e       rx_mode = RX_FREE;
  int             rx_span = 0;

  keyboard_scancode_event_decoder DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .scan_byte_i,
    .map_select_i,
    .map_index_i,
    .map_char_i,
    .out_valid_o,
    .out_stall_i,
    .ev_valid_o,
    .ev_kind_o,
    .ev_char_o,
    .queue_level_o,
    .dropped_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver switches at random between stall patterns.
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end
    rx_span--;
    case (rx_mode)
      RX_FREE:     out_stall_i <= 1'b0;
      RX_RANDOM:   out_stall_i <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: out_stall_i <= ((rx_span % 5) < 2);
      default:     out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_reply(ev_valid_o, ev_kind_o, ev_char_o, queue_level_o, dropped_o);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return CharLoA + 8'($urandom_range(0, 25));
    if (r < 6) return CharUpA + 8'($urandom_range(0, 25));
    if (r == 6) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // One transaction on the input channel; the sender idles between bursts.
  task automatic send_raw(req_e r, logic [7:0] sc, logic sel, logic [6:0] idx,
                          logic [7:0] chr);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    req_type_i   <= r;
    scan_byte_i  <= sc;
    map_select_i <= sel;
    map_index_i  <= idx;
    map_char_i   <= chr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(r, sc, sel, idx, chr);
    burst_left--;
  endtask

  // A scancode that would read a keymap entry never written gets that entry
  // loaded first.
  task automatic send(req_e r, logic [7:0] sc, logic sel, logic [6:0] idx,
                      logic [7:0] chr);
    int k;
    if (r == REQ_SCAN) begin
      k = board.unloaded_entry(sc);
      if (k >= 0)
        send_raw(REQ_MAP, 8'($urandom), k[7], k[6:0], rand_char());
    end
    send_raw(r, sc, sel, idx, chr);
  endtask

  task automatic send_scan(logic [7:0] sc);
    send(REQ_SCAN, sc, 1'($urandom), 7'($urandom), 8'($urandom));
  endtask

  task automatic send_pop();
    send(REQ_POP, 8'($urandom), 1'($urandom), 7'($urandom), 8'($urandom));
  endtask

  task automatic send_map(logic sel, logic [6:0] idx, logic [7:0] chr);
    send(REQ_MAP, 8'($urandom), sel, idx, chr);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_step(int pop_pct);
    logic [7:0] ext_codes[6];
    int         r;
    ext_codes = '{ScUp, ScDown, ScLeft, ScRight, ScPgUp, ScPgDn};
    if ($urandom_range(0, 99) < pop_pct) begin
      send_pop();
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 45) send_scan(8'($urandom_range(0, 127)));
    else if (r < 60) begin
      send_scan(ScExtPrefix);
      if ($urandom_range(0, 5) == 0) send_scan(8'($urandom));
      else send_scan(ext_codes[$urandom_range(0, 5)]);
    end else if (r < 68) begin
      case ($urandom_range(0, 3))
        0: send_scan(ScLShMake);
        1: send_scan(ScRShMake);
        2: send_scan(ScLShBreak);
        default: send_scan(ScRShBreak);
      endcase
    end else if (r < 74) begin
      if ($urandom_range(0, 1)) send_scan(ScExtPrefix);
      send_scan($urandom_range(0, 1) ? ScCtrlMake : ScCtrlBreak);
    end else if (r < 82) send_scan(8'($urandom_range(128, 255)));
    else if (r < 88) send_scan(ScExtPrefix);
    else if (r < 95) send_map(1'($urandom), 7'($urandom), rand_char());
    else if (r < 98) send(REQ_NONE, 8'($urandom), 1'($urandom), 7'($urandom), 8'($urandom));
    else send_scan(8'($urandom));
  endtask

  initial begin
    int pop_pct;
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, unused request, keymap with shift and ctrl, all
    // fixed keys except down, prefix corner cases.
    send_pop();
    send(REQ_NONE, 8'hFF, 1'b1, 7'h7F, 8'hFF);
    send_map(1'b0, 7'h1E, CharLoA);
    send_map(1'b1, 7'h1E, CharUpA);
    send_scan(8'h1E);
    send_scan(ScLShMake);
    send_scan(8'h1E);
    send_scan(ScLShBreak);
    send_scan(ScExtPrefix);
    send_scan(ScCtrlMake);
    send_scan(8'h1E);
    send_scan(ScCtrlBreak);
    send_scan(ScBksp);
    send_scan(ScEnter);
    send_scan(ScUp);
    send_scan(ScPgDn);
    send_scan(ScExtPrefix);
    send_scan(ScLeft);
    send_scan(ScExtPrefix);
    send_scan(ScRight);
    send_scan(ScExtPrefix);
    send_scan(ScLShBreak);
    send_scan(8'h9E);
    // A pop between the prefix and its key leaves the prefix pending.
    send_scan(ScExtPrefix);
    send_pop();
    send_scan(ScPgUp);
    send_map(1'b1, 7'h7F, 8'h00);
    send_map(1'b0, 7'h00, 8'hFF);
    send_scan(8'h00);
    wait_drained();

    pop_pct = 45;
    for (int n = 0; n < RandSteps; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 10;
          1: pop_pct = 45;
          default: pop_pct = 75;
        endcase
      end
      if (n == RandSteps / 2) wait_drained();
      random_step(pop_pct);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.expected_replies.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
